// ===== src/ghbp_pkg.sv =====
// ----------------------------------------------------------------------------
// ghbp_pkg
// shared types, codes and defaults for the generational handle buffer pool
// ----------------------------------------------------------------------------
package ghbp_pkg;

  localparam int SLOTS_DEF      = 16;
  localparam int SLOT_BYTES_DEF = 64;
  localparam int GEN_BITS_DEF   = 16;

  // operation codes as they arrive on the input word
  localparam logic [2:0] FN_NEW  = 3'd0;
  localparam logic [2:0] FN_SET  = 3'd1;
  localparam logic [2:0] FN_SUM  = 3'd2;
  localparam logic [2:0] FN_MOVE = 3'd3;
  localparam logic [2:0] FN_FREE = 3'd4;

  // result status codes
  localparam logic [2:0] ST_HANDLE = 3'd0;
  localparam logic [2:0] ST_OK     = 3'd1;
  localparam logic [2:0] ST_STALE  = 3'd2;
  localparam logic [2:0] ST_BOUNDS = 3'd3;
  localparam logic [2:0] ST_SAME   = 3'd4;
  localparam logic [2:0] ST_SUM    = 3'd5;
  localparam logic [2:0] ST_FULL   = 3'd6;
  localparam logic [2:0] ST_CAP    = 3'd7;

  typedef struct packed {
    logic [2:0]  func;
    logic [7:0]  alloc_size;
    logic [7:0]  slot_index;
    logic [15:0] slot_generation;
    logic [7:0]  byte_offset;
    logic [7:0]  byte_value;
    logic [7:0]  dest_index;
    logic [15:0] dest_generation;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  handle_index;
    logic [15:0] handle_generation;
    logic [13:0] result_value;
    logic [4:0]  live_count;
    logic [10:0] live_bytes;
  } out_word_t;

  typedef enum logic [2:0] {
    OP_NEW,
    OP_SET,
    OP_SUM,
    OP_MOVE,
    OP_FREE,
    OP_BAD
  } op_t;

  // classified command handed from front to back
  typedef struct packed {
    op_t      op;
    logic     cap;
    logic     src_oob;
    logic     dst_oob;
    in_word_t word;
  } cmd_t;

  typedef enum logic [3:0] {
    BS_IDLE,
    BS_SCAN,
    BS_CLEAR,
    BS_SRC,
    BS_DST,
    BS_SUM,
    BS_COPY,
    BS_RELEASE,
    BS_DONE
  } back_state_t;

endpackage

// ===== src/generational_handle_buffer_pool.sv =====
// ----------------------------------------------------------------------------
// generational_handle_buffer_pool
// slot pool addressed by (index, generation) handles, one result word per item
// ----------------------------------------------------------------------------
// throughput: one word at a time in the back end; the byte memory port sets
//   the per-byte cost of zero-fill, sum and copy
// the front queue holds two words, so input is taken while a result waits
// reset: synchronous, active low; clears slot table and totals, byte memory
//   is left as is
module generational_handle_buffer_pool #(
  parameter int SLOTS      = ghbp_pkg::SLOTS_DEF,
  parameter int SLOT_BYTES = ghbp_pkg::SLOT_BYTES_DEF,
  parameter int GEN_BITS   = ghbp_pkg::GEN_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  ghbp_pkg::in_word_t  in_word,
  output logic                out_valid,
  input  logic                out_stall,
  output ghbp_pkg::out_word_t out_word
);

  logic           q_valid;
  logic           q_pop;
  ghbp_pkg::cmd_t q_cmd;

  ghbp_front #(
    .SLOTS      (SLOTS),
    .SLOT_BYTES (SLOT_BYTES)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_cmd    (q_cmd)
  );

  ghbp_back #(
    .SLOTS      (SLOTS),
    .SLOT_BYTES (SLOT_BYTES),
    .GEN_BITS   (GEN_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_cmd     (q_cmd),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

endmodule

// ===== src/ghbp_ram.sv =====
// ----------------------------------------------------------------------------
// ghbp_ram
// generic one-write one-read memory with registered read data
// ----------------------------------------------------------------------------
module ghbp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== src/ghbp_front.sv =====
// ----------------------------------------------------------------------------
// ghbp_front
// accepts input words, decodes and range-checks them, two-entry queue to back
// ----------------------------------------------------------------------------
module ghbp_front #(
  parameter int SLOTS      = ghbp_pkg::SLOTS_DEF,
  parameter int SLOT_BYTES = ghbp_pkg::SLOT_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  ghbp_pkg::in_word_t in_word,
  output logic              q_valid,
  input  logic              q_pop,
  output ghbp_pkg::cmd_t    q_cmd
);

  ghbp_pkg::cmd_t q_r [2];
  ghbp_pkg::cmd_t cls;
  logic       head_r, head_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;

  always_comb begin
    cls      = '0;
    cls.word = in_word;
    unique case (in_word.func)
      ghbp_pkg::FN_NEW:  cls.op = ghbp_pkg::OP_NEW;
      ghbp_pkg::FN_SET:  cls.op = ghbp_pkg::OP_SET;
      ghbp_pkg::FN_SUM:  cls.op = ghbp_pkg::OP_SUM;
      ghbp_pkg::FN_MOVE: cls.op = ghbp_pkg::OP_MOVE;
      ghbp_pkg::FN_FREE: cls.op = ghbp_pkg::OP_FREE;
      default:           cls.op = ghbp_pkg::OP_BAD;
    endcase
    cls.cap     = 32'(in_word.alloc_size) > 32'(SLOT_BYTES);
    cls.src_oob = 32'(in_word.slot_index) >= 32'(SLOTS);
    cls.dst_oob = 32'(in_word.dest_index) >= 32'(SLOTS);
  end

  assign in_stall = (cnt_r == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_cmd    = q_r[head_r];

  always_comb begin
    head_nxt = head_r;
    cnt_nxt  = cnt_r;
    if (q_pop && q_valid) begin
      head_nxt = !head_r;
    end
    if (push && !(q_pop && q_valid)) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (!push && q_pop && q_valid) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      head_r <= head_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // tail slot is head plus count
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[head_r ^ cnt_r[0]] <= cls;
    end
  end

endmodule

// ===== src/ghbp_back.sv =====
// ----------------------------------------------------------------------------
// ghbp_back
// executes one command at a time against the slot table and byte memory
// ----------------------------------------------------------------------------
module ghbp_back #(
  parameter int SLOTS      = ghbp_pkg::SLOTS_DEF,
  parameter int SLOT_BYTES = ghbp_pkg::SLOT_BYTES_DEF,
  parameter int GEN_BITS   = ghbp_pkg::GEN_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  output logic                q_pop,
  input  ghbp_pkg::cmd_t      q_cmd,
  output logic                out_valid,
  input  logic                out_stall,
  output ghbp_pkg::out_word_t out_word
);

  localparam int IW   = $clog2(SLOTS);
  localparam int LW   = $clog2(SLOT_BYTES + 1);
  localparam int AW   = $clog2(SLOTS * SLOT_BYTES);
  localparam int SW   = $clog2(SLOT_BYTES * 255 + 1);
  localparam int CNTW = $clog2(SLOTS + 1);
  localparam int BW   = $clog2(SLOTS * SLOT_BYTES + 1);
  localparam int GCW  = (GEN_BITS > 16) ? GEN_BITS : 16;
  localparam int CW   = (LW > 8) ? LW : 8;

  ghbp_pkg::back_state_t state_r, state_nxt;
  ghbp_pkg::cmd_t        cmd_r, cmd_nxt;

  logic [GEN_BITS-1:0] gen_r [SLOTS];
  logic                occ_r [SLOTS];
  logic [LW-1:0]       len_r [SLOTS];

  logic [IW-1:0]       tidx_r, tidx_nxt;
  logic [LW-1:0]       ptr_r, ptr_nxt;
  logic [LW-1:0]       wptr_r, wptr_nxt;
  logic                pend_r, pend_nxt;
  logic [SW-1:0]       acc_r, acc_nxt;
  logic [LW-1:0]       src_len_r, src_len_nxt;
  logic [LW-1:0]       dst_len_r, dst_len_nxt;
  logic [2:0]          status_r, status_nxt;
  logic [IW-1:0]       hidx_r, hidx_nxt;
  logic [GEN_BITS-1:0] hgen_r, hgen_nxt;
  logic [SW-1:0]       result_r, result_nxt;
  logic [CNTW-1:0]     cnt_r, cnt_nxt;
  logic [BW-1:0]       bytes_r, bytes_nxt;
  logic                out_valid_r, out_valid_nxt;
  ghbp_pkg::out_word_t out_word_r, out_word_nxt;

  logic                tbl_we;
  logic [GEN_BITS-1:0] tbl_gen;
  logic                tbl_occ;
  logic [LW-1:0]       tbl_len;

  logic                ram_we, ram_re;
  logic [AW-1:0]       ram_waddr, ram_raddr;
  logic [7:0]          ram_wdata, ram_rdata;

  logic [GEN_BITS-1:0] t_gen;
  logic                t_occ;
  logic [LW-1:0]       t_len;
  logic [15:0]         hdl_gen;
  logic                t_live;
  logic [IW-1:0]       src_idx, dst_idx, new_idx;
  logic [LW-1:0]       size_l;
  logic                off_ge, fits, rd_more, out_free;
  logic [AW-1:0]       src_base, dst_base, t_base;
  logic [GCW-1:0]      hgen_ext;
  logic [7:0]          hidx_ext;
  logic [31:0]         res_ext, cnt_ext, bytes_ext;

  assign t_gen    = gen_r[tidx_r];
  assign t_occ    = occ_r[tidx_r];
  assign t_len    = len_r[tidx_r];
  assign hdl_gen  = (state_r == ghbp_pkg::BS_DST) ? cmd_r.word.dest_generation
                                                  : cmd_r.word.slot_generation;
  assign t_live   = t_occ && (GCW'(t_gen) == GCW'(hdl_gen));
  assign src_idx  = cmd_r.word.slot_index[IW-1:0];
  assign dst_idx  = cmd_r.word.dest_index[IW-1:0];
  assign new_idx  = q_cmd.word.slot_index[IW-1:0];
  assign size_l   = LW'(cmd_r.word.alloc_size);
  assign off_ge   = CW'(cmd_r.word.byte_offset) >= CW'(t_len);
  assign fits     = ((LW+1)'(src_len_r) + (LW+1)'(t_len)) <= (LW+1)'(SLOT_BYTES);
  assign rd_more  = ptr_r < src_len_r;
  assign out_free = !out_valid_r || !out_stall;
  assign src_base = AW'(src_idx) * AW'(SLOT_BYTES);
  assign dst_base = AW'(dst_idx) * AW'(SLOT_BYTES);
  assign t_base   = AW'(tidx_r) * AW'(SLOT_BYTES);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ghbp_pkg::BS_IDLE: begin
        if (q_valid) begin
          if (q_cmd.op == ghbp_pkg::OP_NEW) begin
            state_nxt = q_cmd.cap ? ghbp_pkg::BS_DONE : ghbp_pkg::BS_SCAN;
          end else if (q_cmd.op == ghbp_pkg::OP_BAD || q_cmd.src_oob) begin
            state_nxt = ghbp_pkg::BS_DONE;
          end else begin
            state_nxt = ghbp_pkg::BS_SRC;
          end
        end
      end
      ghbp_pkg::BS_SCAN: begin
        if (!t_occ) begin
          state_nxt = (size_l == '0) ? ghbp_pkg::BS_DONE : ghbp_pkg::BS_CLEAR;
        end else if (tidx_r == IW'(SLOTS - 1)) begin
          state_nxt = ghbp_pkg::BS_DONE;
        end
      end
      ghbp_pkg::BS_CLEAR: begin
        if (ptr_r + LW'(1) == size_l) begin
          state_nxt = ghbp_pkg::BS_DONE;
        end
      end
      ghbp_pkg::BS_SRC: begin
        if (!t_live) begin
          state_nxt = ghbp_pkg::BS_DONE;
        end else if (cmd_r.op == ghbp_pkg::OP_SUM) begin
          state_nxt = ghbp_pkg::BS_SUM;
        end else if (cmd_r.op == ghbp_pkg::OP_MOVE && !cmd_r.dst_oob) begin
          state_nxt = ghbp_pkg::BS_DST;
        end else begin
          state_nxt = ghbp_pkg::BS_DONE;
        end
      end
      ghbp_pkg::BS_DST: begin
        if (!t_live || dst_idx == src_idx || !fits) begin
          state_nxt = ghbp_pkg::BS_DONE;
        end else if (src_len_r == '0) begin
          state_nxt = ghbp_pkg::BS_RELEASE;
        end else begin
          state_nxt = ghbp_pkg::BS_COPY;
        end
      end
      ghbp_pkg::BS_SUM: begin
        if (!rd_more && !pend_r) begin
          state_nxt = ghbp_pkg::BS_DONE;
        end
      end
      ghbp_pkg::BS_COPY: begin
        if (!rd_more && !pend_r) begin
          state_nxt = ghbp_pkg::BS_RELEASE;
        end
      end
      ghbp_pkg::BS_RELEASE: state_nxt = ghbp_pkg::BS_DONE;
      ghbp_pkg::BS_DONE: begin
        if (out_free) begin
          state_nxt = ghbp_pkg::BS_IDLE;
        end
      end
      default: state_nxt = ghbp_pkg::BS_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    cmd_nxt       = cmd_r;
    tidx_nxt      = tidx_r;
    ptr_nxt       = ptr_r;
    wptr_nxt      = wptr_r;
    pend_nxt      = 1'b0;
    acc_nxt       = acc_r;
    src_len_nxt   = src_len_r;
    dst_len_nxt   = dst_len_r;
    status_nxt    = status_r;
    hidx_nxt      = hidx_r;
    hgen_nxt      = hgen_r;
    result_nxt    = result_r;
    cnt_nxt       = cnt_r;
    bytes_nxt     = bytes_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_word_nxt  = out_word_r;
    q_pop         = 1'b0;
    tbl_we        = 1'b0;
    tbl_gen       = t_gen;
    tbl_occ       = t_occ;
    tbl_len       = t_len;
    ram_we        = 1'b0;
    ram_waddr     = '0;
    ram_wdata     = '0;
    ram_re        = 1'b0;
    ram_raddr     = '0;
    unique case (state_r)
      ghbp_pkg::BS_IDLE: begin
        if (q_valid) begin
          q_pop      = 1'b1;
          cmd_nxt    = q_cmd;
          hidx_nxt   = '0;
          hgen_nxt   = '0;
          result_nxt = '0;
          status_nxt = ghbp_pkg::ST_STALE;
          if (q_cmd.op == ghbp_pkg::OP_NEW) begin
            tidx_nxt = '0;
            if (q_cmd.cap) begin
              status_nxt = ghbp_pkg::ST_CAP;
            end
          end else if (!q_cmd.src_oob) begin
            tidx_nxt = new_idx;
          end
        end
      end
      ghbp_pkg::BS_SCAN: begin
        ptr_nxt = '0;
        if (!t_occ) begin
          tbl_we     = 1'b1;
          tbl_gen    = t_gen + GEN_BITS'(1);
          tbl_occ    = 1'b1;
          tbl_len    = size_l;
          cnt_nxt    = cnt_r + CNTW'(1);
          bytes_nxt  = bytes_r + BW'(size_l);
          status_nxt = ghbp_pkg::ST_HANDLE;
          hidx_nxt   = tidx_r;
          hgen_nxt   = t_gen + GEN_BITS'(1);
        end else if (tidx_r == IW'(SLOTS - 1)) begin
          status_nxt = ghbp_pkg::ST_FULL;
        end else begin
          tidx_nxt = tidx_r + IW'(1);
        end
      end
      ghbp_pkg::BS_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = t_base + AW'(ptr_r);
        ptr_nxt   = ptr_r + LW'(1);
      end
      ghbp_pkg::BS_SRC: begin
        src_len_nxt = t_len;
        ptr_nxt     = '0;
        acc_nxt     = '0;
        if (t_live) begin
          case (cmd_r.op)
            ghbp_pkg::OP_SET: begin
              if (off_ge) begin
                status_nxt = ghbp_pkg::ST_BOUNDS;
              end else begin
                ram_we     = 1'b1;
                ram_waddr  = src_base + AW'(cmd_r.word.byte_offset);
                ram_wdata  = cmd_r.word.byte_value;
                status_nxt = ghbp_pkg::ST_OK;
              end
            end
            ghbp_pkg::OP_FREE: begin
              tbl_we     = 1'b1;
              tbl_occ    = 1'b0;
              tbl_len    = '0;
              cnt_nxt    = cnt_r - CNTW'(1);
              bytes_nxt  = bytes_r - BW'(t_len);
              status_nxt = ghbp_pkg::ST_OK;
            end
            ghbp_pkg::OP_MOVE: begin
              if (!cmd_r.dst_oob) begin
                tidx_nxt = dst_idx;
              end
            end
            default: ;
          endcase
        end
      end
      ghbp_pkg::BS_DST: begin
        ptr_nxt     = '0;
        wptr_nxt    = '0;
        dst_len_nxt = t_len;
        if (!t_live) begin
          status_nxt = ghbp_pkg::ST_STALE;
        end else if (dst_idx == src_idx) begin
          status_nxt = ghbp_pkg::ST_SAME;
        end else if (!fits) begin
          status_nxt = ghbp_pkg::ST_CAP;
        end else begin
          tbl_we     = 1'b1;
          tbl_len    = t_len + src_len_r;
          result_nxt = SW'(t_len + src_len_r);
          if (src_len_r == '0) begin
            tidx_nxt = src_idx;
          end
        end
      end
      ghbp_pkg::BS_SUM: begin
        ram_re    = rd_more;
        ram_raddr = src_base + AW'(ptr_r);
        pend_nxt  = rd_more;
        if (rd_more) begin
          ptr_nxt = ptr_r + LW'(1);
        end
        if (pend_r) begin
          acc_nxt = acc_r + SW'(ram_rdata);
        end
        if (!rd_more && !pend_r) begin
          status_nxt = ghbp_pkg::ST_SUM;
          result_nxt = acc_r;
        end
      end
      ghbp_pkg::BS_COPY: begin
        // read a source byte, write it to the destination tail in the next cycle
        ram_re    = rd_more;
        ram_raddr = src_base + AW'(ptr_r);
        pend_nxt  = rd_more;
        if (rd_more) begin
          ptr_nxt = ptr_r + LW'(1);
        end
        ram_we    = pend_r;
        ram_waddr = dst_base + AW'(dst_len_r) + AW'(wptr_r);
        ram_wdata = ram_rdata;
        if (pend_r) begin
          wptr_nxt = wptr_r + LW'(1);
        end
        if (!rd_more && !pend_r) begin
          tidx_nxt = src_idx;
        end
      end
      ghbp_pkg::BS_RELEASE: begin
        tbl_we     = 1'b1;
        tbl_occ    = 1'b0;
        tbl_len    = '0;
        cnt_nxt    = cnt_r - CNTW'(1);
        status_nxt = ghbp_pkg::ST_OK;
      end
      ghbp_pkg::BS_DONE: begin
        if (out_free) begin
          out_valid_nxt                  = 1'b1;
          out_word_nxt.status            = status_r;
          out_word_nxt.handle_index      = hidx_ext[3:0];
          out_word_nxt.handle_generation = hgen_ext[15:0];
          out_word_nxt.result_value      = res_ext[13:0];
          out_word_nxt.live_count        = cnt_ext[4:0];
          out_word_nxt.live_bytes        = bytes_ext[10:0];
        end
      end
      default: ;
    endcase
  end

  assign hidx_ext  = 8'(hidx_r);
  assign hgen_ext  = GCW'(hgen_r);
  assign res_ext   = 32'(result_r);
  assign cnt_ext   = 32'(cnt_r);
  assign bytes_ext = 32'(bytes_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ghbp_pkg::BS_IDLE;
      cnt_r       <= '0;
      bytes_r     <= '0;
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
      for (int i = 0; i < SLOTS; i++) begin
        gen_r[i] <= '0;
        occ_r[i] <= 1'b0;
        len_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      bytes_r     <= bytes_nxt;
      out_valid_r <= out_valid_nxt;
      pend_r      <= pend_nxt;
      if (tbl_we) begin
        gen_r[tidx_r] <= tbl_gen;
        occ_r[tidx_r] <= tbl_occ;
        len_r[tidx_r] <= tbl_len;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    tidx_r     <= tidx_nxt;
    ptr_r      <= ptr_nxt;
    wptr_r     <= wptr_nxt;
    acc_r      <= acc_nxt;
    src_len_r  <= src_len_nxt;
    dst_len_r  <= dst_len_nxt;
    status_r   <= status_nxt;
    hidx_r     <= hidx_nxt;
    hgen_r     <= hgen_nxt;
    result_r   <= result_nxt;
    out_word_r <= out_word_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  ghbp_ram #(
    .WIDTH (8),
    .DEPTH (SLOTS * SLOT_BYTES)
  ) u_bytes (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule
